/* sv/rsa_modular_exponentiation_assert.svh */
// assertion macros for the modular exponentiation block
// expects clk_i and rst_ni in the scope of use
`ifndef RSA_MODULAR_EXPONENTIATION_ASSERT_SVH
`define RSA_MODULAR_EXPONENTIATION_ASSERT_SVH

// same-cycle implication
`define RSA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rsa assertion failed");

// next-cycle implication
`define RSA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rsa assertion failed");

`endif

/* sv/rsa_mexp_pkg.sv */
// shared types and constants for the modular exponentiation block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package rsa_mexp_pkg;

  localparam int unsigned DATA_W        = 32;
  localparam int unsigned MOD_WIDTH_DEF = 32;
  localparam int unsigned BIT_CNT_W     = $clog2(DATA_W);
  localparam int unsigned CFG_IDX_W     = 2;

  localparam logic [DATA_W-1:0] BYTE_MAX = 32'd255;

  localparam logic [DATA_W-1:0] MODULUS_RST     = 32'd73716439;
  localparam logic [DATA_W-1:0] PUB_EXP_RST     = 32'd3;
  localparam logic [DATA_W-1:0] PRIV_EXP_RST    = 32'd49132747;

  localparam logic [CFG_IDX_W-1:0] CFG_MODULUS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PUB_EXP  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PRIV_EXP = 2'd2;

  localparam logic MODE_ENCRYPT = 1'b0;
  localparam logic MODE_DECRYPT = 1'b1;

  typedef struct packed {
    logic              mode;
    logic [DATA_W-1:0] value;
  } rsa_in_t;

  typedef struct packed {
    logic [DATA_W-1:0] result;
    logic              out_of_range;
  } rsa_out_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mm_status_t;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_REDUCE = 5'b00010,
    ST_STEP   = 5'b00100,
    ST_MUL    = 5'b01000,
    ST_SQR    = 5'b10000
  } rsa_state_e;

endpackage

`default_nettype wire

/* sv/rsa_mexp_modmul.sv */
// bit-serial interleaved modular multiplier, one multiplier bit per cycle
// depends on rsa_mexp_pkg
`timescale 1ns / 1ps
`default_nettype none

module rsa_mexp_modmul
  import rsa_mexp_pkg::*;
#(
  parameter int unsigned MOD_WIDTH = MOD_WIDTH_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire logic [MOD_WIDTH-1:0] a_i,
  input  wire logic [DATA_W-1:0]    b_i,
  input  wire logic [MOD_WIDTH-1:0] n_i,
  output mm_status_t                stat_o,
  output logic [MOD_WIDTH-1:0]      prod_o
);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [BIT_CNT_W-1:0] cnt_q, cnt_d;
  logic [MOD_WIDTH-1:0] r_q, r_d;
  logic [MOD_WIDTH-1:0] a_q;
  logic [MOD_WIDTH-1:0] n_q;
  logic [DATA_W-1:0]    b_q;

  logic [MOD_WIDTH:0]   dbl;
  logic [MOD_WIDTH:0]   dbl_red;
  logic [MOD_WIDTH:0]   sum;
  logic [MOD_WIDTH:0]   sum_red;
  logic [MOD_WIDTH:0]   n_ext;

  // r = (2r + bit*a) mod n, operands below n
  always_comb begin
    n_ext   = {1'b0, n_q};
    dbl     = {r_q, 1'b0};
    dbl_red = (dbl >= n_ext) ? dbl - n_ext : dbl;
    sum     = dbl_red + (b_q[DATA_W-1] ? {1'b0, a_q} : '0);
    sum_red = (sum >= n_ext) ? sum - n_ext : sum;
  end

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    r_d    = r_q;
    if (busy_q) begin
      r_d   = sum_red[MOD_WIDTH-1:0];
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == BIT_CNT_W'(DATA_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end else if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      r_d    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q <= r_d;
    if (!busy_q && start_i) begin
      a_q <= a_i;
      b_q <= b_i;
      n_q <= n_i;
    end else if (busy_q) begin
      b_q <= {b_q[DATA_W-2:0], 1'b0};
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign prod_o      = r_q;

endmodule

`default_nettype wire

/* sv/rsa_modular_exponentiation.sv */
// rsa modular exponentiation, right-to-left square and multiply
// depends on rsa_mexp_pkg, rsa_mexp_modmul and rsa_modular_exponentiation_assert.svh
//
// usage:
//   command channel: drive in_i and raise start_i; the transfer happens at an
//   edge where start_i is high and busy_o is low. busy_o stays high until the
//   result is out.
//   result channel: res_valid_o is high for exactly one cycle with res_o; the
//   receiver cannot stall and must take it in that cycle.
//   config channel: cfg_valid_i with cfg_index_i and cfg_data_i, cfg_ready_o is
//   always high. write only while busy_o is low.
// sequence: the base is first reduced by one modular multiplication, then each
//   exponent bit up to the highest set bit costs a step and a square, plus a
//   multiply where the bit is set. all multiplications run in the shared
//   bit-serial multiplier. one item at a time.
//   a modulus below two gives result 0 in the cycle after the transfer.
// reset: the config registers return to their default key, no item is in flight.
`timescale 1ns / 1ps
`default_nettype none
`include "rsa_modular_exponentiation_assert.svh"

module rsa_modular_exponentiation
  import rsa_mexp_pkg::*;
#(
  parameter int unsigned MOD_WIDTH = MOD_WIDTH_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  output logic                      busy_o,
  input  rsa_in_t                   in_i,
  output logic                      res_valid_o,
  output rsa_out_t                  res_o,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [DATA_W-1:0]    cfg_data_i
);

  logic [DATA_W-1:0]    modulus_q;
  logic [DATA_W-1:0]    pub_exp_q;
  logic [DATA_W-1:0]    priv_exp_q;

  rsa_state_e           state_q, state_d;
  logic                 mm_start_q, mm_start_d;
  logic                 res_valid_q, res_valid_d;
  rsa_out_t             res_q, res_d;
  logic                 mode_q, mode_d;
  logic [DATA_W-1:0]    val_q, val_d;
  logic [DATA_W-1:0]    exp_q, exp_d;
  logic [MOD_WIDTH-1:0] acc_q, acc_d;
  logic [MOD_WIDTH-1:0] base_q, base_d;
  logic [MOD_WIDTH-1:0] n_q, n_d;

  logic [MOD_WIDTH-1:0] n_cfg;
  logic                 n_small;
  logic                 accept;
  logic                 mm_phase;

  mm_status_t           mm_stat;
  logic [MOD_WIDTH-1:0] mm_a;
  logic [DATA_W-1:0]    mm_b;
  logic [MOD_WIDTH-1:0] mm_prod;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q  <= MODULUS_RST;
      pub_exp_q  <= PUB_EXP_RST;
      priv_exp_q <= PRIV_EXP_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_MODULUS:  modulus_q  <= cfg_data_i;
        CFG_PUB_EXP:  pub_exp_q  <= cfg_data_i;
        CFG_PRIV_EXP: priv_exp_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign n_cfg    = modulus_q[MOD_WIDTH-1:0];
  assign n_small  = (n_cfg <= MOD_WIDTH'(1));
  assign busy_o   = (state_q != ST_IDLE);
  assign accept   = start_i && !busy_o;
  assign mm_phase = (state_q == ST_REDUCE) || (state_q == ST_MUL) || (state_q == ST_SQR);

  always_comb begin
    case (state_q)
      ST_REDUCE: begin
        mm_a = MOD_WIDTH'(1);
        mm_b = val_q;
      end
      ST_MUL: begin
        mm_a = acc_q;
        mm_b = DATA_W'(base_q);
      end
      default: begin
        mm_a = base_q;
        mm_b = DATA_W'(base_q);
      end
    endcase
  end

  rsa_mexp_modmul #(
    .MOD_WIDTH(MOD_WIDTH)
  ) u_modmul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mm_start_q),
    .a_i    (mm_a),
    .b_i    (mm_b),
    .n_i    (n_q),
    .stat_o (mm_stat),
    .prod_o (mm_prod)
  );

  always_comb begin
    state_d     = state_q;
    mm_start_d  = 1'b0;
    res_valid_d = 1'b0;
    res_d       = res_q;
    mode_d      = mode_q;
    val_d       = val_q;
    exp_d       = exp_q;
    acc_d       = acc_q;
    base_d      = base_q;
    n_d         = n_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (n_small) begin
            res_valid_d        = 1'b1;
            res_d.result       = '0;
            res_d.out_of_range = 1'b0;
          end else begin
            state_d    = ST_REDUCE;
            mm_start_d = 1'b1;
            mode_d     = in_i.mode;
            n_d        = n_cfg;
            acc_d      = MOD_WIDTH'(1);
            if (in_i.mode == MODE_DECRYPT) begin
              val_d = in_i.value;
              exp_d = priv_exp_q;
            end else begin
              val_d = in_i.value & BYTE_MAX;
              exp_d = pub_exp_q;
            end
          end
        end
      end
      ST_REDUCE: begin
        if (mm_stat.done) begin
          base_d  = mm_prod;
          state_d = ST_STEP;
        end
      end
      ST_STEP: begin
        if (exp_q == '0) begin
          state_d     = ST_IDLE;
          res_valid_d = 1'b1;
          if (mode_q == MODE_DECRYPT && DATA_W'(acc_q) > BYTE_MAX) begin
            res_d.result       = '0;
            res_d.out_of_range = 1'b1;
          end else begin
            res_d.result       = DATA_W'(acc_q);
            res_d.out_of_range = 1'b0;
          end
        end else if (exp_q[0]) begin
          state_d    = ST_MUL;
          mm_start_d = 1'b1;
        end else begin
          state_d    = ST_SQR;
          mm_start_d = 1'b1;
        end
      end
      ST_MUL: begin
        if (mm_stat.done) begin
          acc_d      = mm_prod;
          state_d    = ST_SQR;
          mm_start_d = 1'b1;
        end
      end
      ST_SQR: begin
        if (mm_stat.done) begin
          base_d  = mm_prod;
          exp_d   = exp_q >> 1;
          state_d = ST_STEP;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mm_start_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mm_start_q  <= mm_start_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q  <= res_d;
    mode_q <= mode_d;
    val_q  <= val_d;
    exp_q  <= exp_d;
    acc_q  <= acc_d;
    base_q <= base_d;
    n_q    <= n_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  `RSA_ASSERT_NOW(a_res_only_idle, res_valid_q, state_q == ST_IDLE)
  `RSA_ASSERT_NEXT(a_accept_goes_busy, accept && !n_small, busy_o && !res_valid_o)
  `RSA_ASSERT_NOW(a_mm_done_in_mult, mm_stat.done, mm_phase)
  `RSA_ASSERT_NOW(a_mm_start_free, mm_start_q, !mm_stat.busy && !mm_stat.done)
  `RSA_ASSERT_NOW(a_range_zero, res_valid_q && res_q.out_of_range, res_q.result == '0)

endmodule

`default_nettype wire
